// File: rtl/qhce_pkg.sv
package qhce_pkg;

    localparam int COORD_W  = 32;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 64;
    localparam int T_FRAC   = 16;
    localparam int T_W      = T_FRAC + 2;
    localparam int COEF_W   = 42;
    localparam int PROD_W   = COEF_W + T_W;
    localparam int NUM_REGS = 6;
    localparam int NUM_TERM = 6;
    localparam int NUM_COEF = 2 * NUM_TERM;
    localparam int IDX_W    = 3;
    localparam int BASIS_W  = 6;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [IDX_W-1:0] {
        REG_START_POINT = 3'd0,
        REG_START_VEL   = 3'd1,
        REG_START_ACCEL = 3'd2,
        REG_END_POINT   = 3'd3,
        REG_END_VEL     = 3'd4,
        REG_END_ACCEL   = 3'd5
    } t_reg_idx;

    localparam logic [IDX_W-1:0] NUM_REGS_IDX = IDX_W'(NUM_REGS);

    // Operand order of the basis rows: P0, V0, A0, A1, V1, P1.
    localparam t_reg_idx REG_ORDER [NUM_TERM] = '{
        REG_START_POINT, REG_START_VEL, REG_START_ACCEL,
        REG_END_ACCEL, REG_END_VEL, REG_END_POINT
    };

    // Quintic Hermite basis times two. Columns run from t^5 down to t^0.
    localparam logic signed [BASIS_W-1:0] BASIS2 [NUM_TERM][NUM_TERM] = '{
        '{-6'sd12,  6'sd30, -6'sd20, 6'sd0, 6'sd0, 6'sd2},
        '{-6'sd6,   6'sd16, -6'sd12, 6'sd0, 6'sd2, 6'sd0},
        '{-6'sd1,   6'sd3,  -6'sd3,  6'sd1, 6'sd0, 6'sd0},
        '{ 6'sd1,  -6'sd2,   6'sd1,  6'sd0, 6'sd0, 6'sd0},
        '{-6'sd6,   6'sd14, -6'sd8,  6'sd0, 6'sd0, 6'sd0},
        '{ 6'sd12, -6'sd30,  6'sd20, 6'sd0, 6'sd0, 6'sd0}
    };

    localparam logic signed [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (T_FRAC - 1);

    typedef struct packed {
        logic                  valid;
        logic signed [T_W-1:0] t;
    } t_stage;

endpackage

// File: rtl/qhce_coef.sv
module qhce_coef
    import qhce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_coef            o_coef [NUM_COEF]
);

    logic [CFG_W-1:0] r_regs [NUM_REGS];
    logic [CFG_W-1:0] n_regs [NUM_REGS];
    t_coef            r_coef [NUM_COEF];
    t_coef            n_coef [NUM_COEF];

    always_comb begin
        logic [OUT_W-1:0]         half;
        logic signed [COORD_W-1:0] m_narrow;
        t_coef                     m [NUM_TERM];
        t_coef                     s;
        for (int r = 0; r < NUM_REGS; r++) begin
            n_regs[r] = r_regs[r];
        end
        if (i_cfg_valid && (i_cfg_index < NUM_REGS_IDX)) begin
            n_regs[i_cfg_index] = i_cfg_data;
        end
        for (int axis = 0; axis < 2; axis++) begin
            for (int i = 0; i < NUM_TERM; i++) begin
                half     = (axis == 0) ? n_regs[REG_ORDER[i]][CFG_W-1:OUT_W]
                                       : n_regs[REG_ORDER[i]][OUT_W-1:0];
                m_narrow = half[COORD_W-1:0];
                m[i]     = COEF_W'(m_narrow);
            end
            for (int k = 0; k < NUM_TERM; k++) begin
                s = '0;
                for (int i = 0; i < NUM_TERM; i++) begin
                    s = s + m[i] * COEF_W'(BASIS2[i][k]);
                end
                n_coef[axis * NUM_TERM + k] = s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_regs[r] <= '0;
            end
            for (int c = 0; c < NUM_COEF; c++) begin
                r_coef[c] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < NUM_REGS_IDX)) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_regs[r] <= n_regs[r];
            end
            for (int c = 0; c < NUM_COEF; c++) begin
                r_coef[c] <= n_coef[c];
            end
        end
    end

    assign o_coef = r_coef;

endmodule

// File: rtl/qhce_cell.sv
module qhce_cell
    import qhce_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    input  t_coef  i_acc_x,
    input  t_coef  i_acc_y,
    input  t_coef  i_coef_x,
    input  t_coef  i_coef_y,
    output t_stage o_stage,
    output t_coef  o_acc_x,
    output t_coef  o_acc_y
);

    t_stage r_stage;
    t_coef  r_acc_x;
    t_coef  r_acc_y;
    t_coef  n_acc_x;
    t_coef  n_acc_y;

    function automatic t_coef horner_step(t_coef acc, logic signed [T_W-1:0] t,
                                          t_coef coef);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] shifted;
        t_coef                    rounded;
        prod    = PROD_W'(acc) * PROD_W'(t);
        shifted = (prod + PROD_HALF) >>> T_FRAC;
        rounded = shifted[COEF_W-1:0];
        return rounded + coef;
    endfunction

    always_comb begin
        n_acc_x = horner_step(i_acc_x, i_stage.t, i_coef_x);
        n_acc_y = horner_step(i_acc_y, i_stage.t, i_coef_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
        r_stage.t <= i_stage.t;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
    end

    assign o_stage = r_stage;
    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;

endmodule

// File: rtl/quintic_hermite_curve_eval.sv
// o_valid strobes when an accepted parameter has passed the registers named below.
// Throughput: one parameter per clock cycle; busy stays low and the receiver cannot stall.
// The delay is one input register, five Horner cells and one rounding register.
// A configuration transaction is always taken, and the coefficients are registered at the same edge as the write.
// Synchronous active-low reset clears the configuration registers, coefficients and valid flags.
module quintic_hermite_curve_eval
    import qhce_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [T_W-1:0]   i_param_t,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_point_x,
    output logic signed [OUT_W-1:0] o_point_y,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int NUM_CELLS = NUM_TERM - 1;
    localparam int RND_W     = COEF_W + 1;
    localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) << (COORD_W - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

    t_coef  w_coef  [NUM_COEF];
    t_stage w_stage [NUM_CELLS+1];
    t_coef  w_acc_x [NUM_CELLS+1];
    t_coef  w_acc_y [NUM_CELLS+1];

    t_stage r_in;
    t_stage n_in;
    logic   r_valid;
    logic signed [OUT_W-1:0] r_point_x;
    logic signed [OUT_W-1:0] r_point_y;
    logic signed [OUT_W-1:0] n_point_x;
    logic signed [OUT_W-1:0] n_point_y;

    function automatic logic signed [OUT_W-1:0] round_sat(t_coef acc);
        logic signed [RND_W-1:0]   rnd;
        logic signed [COORD_W-1:0] sat;
        rnd = (RND_W'(acc) + RND_W'(1)) >>> 1;
        if (rnd > SAT_HI) begin
            sat = SAT_HI[COORD_W-1:0];
        end else if (rnd < SAT_LO) begin
            sat = SAT_LO[COORD_W-1:0];
        end else begin
            sat = rnd[COORD_W-1:0];
        end
        return OUT_W'(sat);
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    qhce_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef)
    );

    always_comb begin
        n_in.valid = start && !busy;
        if (i_param_t < 0) begin
            n_in.t = '0;
        end else if (i_param_t > T_ONE) begin
            n_in.t = T_ONE;
        end else begin
            n_in.t = i_param_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= n_in.valid;
        end
        r_in.t <= n_in.t;
    end

    assign w_stage[0] = r_in;
    assign w_acc_x[0] = w_coef[0];
    assign w_acc_y[0] = w_coef[NUM_TERM];

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        qhce_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_stage  (w_stage[g]),
            .i_acc_x  (w_acc_x[g]),
            .i_acc_y  (w_acc_y[g]),
            .i_coef_x (w_coef[g + 1]),
            .i_coef_y (w_coef[NUM_TERM + g + 1]),
            .o_stage  (w_stage[g + 1]),
            .o_acc_x  (w_acc_x[g + 1]),
            .o_acc_y  (w_acc_y[g + 1])
        );
    end

    always_comb begin
        n_point_x = round_sat(w_acc_x[NUM_CELLS]);
        n_point_y = round_sat(w_acc_y[NUM_CELLS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_stage[NUM_CELLS].valid;
        end
        r_point_x <= n_point_x;
        r_point_y <= n_point_y;
    end

    assign o_valid   = r_valid;
    assign o_point_x = r_point_x;
    assign o_point_y = r_point_y;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("An accepted transaction produced no result.");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("A result appeared without an accepted transaction.");

    a_t_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in.valid |-> (r_in.t >= 0 && r_in.t <= T_ONE))
        else $error("The curve parameter left the unit interval.");

endmodule

// File: verif/tb_quintic_hermite_curve_eval.sv
`timescale 1ns / 1ps

module tb_quintic_hermite_curve_eval;
    import qhce_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 7;
    localparam int LATENCY      = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ROUNDS = 14;
    localparam int ROUND_POINTS  = 100;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_HEAVY  = 53;
    localparam int IDLE_LIGHT  = 28;

    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ZERO = 32'h0000_0000;
    localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;

    localparam logic signed [T_W-1:0] T_LOW  = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_HIGH = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_ZERO = '0;
    localparam logic signed [T_W-1:0] T_HALF = T_ONE >>> 1;

    localparam logic [IDX_W-1:0] IDX_SPARE_LO = NUM_REGS_IDX;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI = '1;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } t_point;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic signed [T_W-1:0]   i_param_t   = '0;
    logic                    i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    busy;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_point_x;
    logic signed [OUT_W-1:0] o_point_y;
    logic                    o_cfg_ready;

    logic [CFG_W-1:0] curve_regs [NUM_REGS];
    longint           curve_coeffs [NUM_COEF];
    t_point           pending_points [$];

    int idle_pct      = IDLE_NONE;
    int failures      = 0;
    int params_sent   = 0;
    int points_seen   = 0;
    int reg_writes    = 0;
    int curves_loaded = 0;
    int cycle_count   = 0;

    quintic_hermite_curve_eval u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_param_t   (i_param_t),
        .o_valid     (o_valid),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_quintic_hermite_curve_eval failed");
            $finish;
        end
    end

    // Doubled Hermite weights; rows are P0, V0, A0, A1, V1, P1 and columns t^5 down to t^0.
    function automatic longint hermite_weight(input int row, input int col);
        longint w [6];
        case (row)
            0:       w = '{-12,  30, -20, 0, 0, 2};
            1:       w = '{ -6,  16, -12, 0, 2, 0};
            2:       w = '{ -1,   3,  -3, 1, 0, 0};
            3:       w = '{  1,  -2,   1, 0, 0, 0};
            4:       w = '{ -6,  14,  -8, 0, 0, 0};
            default: w = '{ 12, -30,  20, 0, 0, 0};
        endcase
        return w[col];
    endfunction

    function automatic t_reg_idx weight_source(input int row);
        case (row)
            0:       return REG_START_POINT;
            1:       return REG_START_VEL;
            2:       return REG_START_ACCEL;
            3:       return REG_END_ACCEL;
            4:       return REG_END_VEL;
            default: return REG_END_POINT;
        endcase
    endfunction

    function automatic void rebuild_curve();
        longint      operand [6];
        longint      sum;
        logic [31:0] half;
        for (int axis = 0; axis < 2; axis++) begin
            for (int i = 0; i < NUM_TERM; i++) begin
                half = (axis == 0) ? curve_regs[weight_source(i)][63:32]
                                   : curve_regs[weight_source(i)][31:0];
                operand[i] = longint'($signed(half));
            end
            for (int k = 0; k < NUM_TERM; k++) begin
                sum = 0;
                for (int i = 0; i < NUM_TERM; i++) begin
                    sum += operand[i] * hermite_weight(i, k);
                end
                curve_coeffs[axis * NUM_TERM + k] = sum;
            end
        end
    endfunction

    function automatic longint round_half_up(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [OUT_W-1:0] horner_axis(input int axis, input longint t);
        longint acc;
        acc = curve_coeffs[axis * NUM_TERM];
        for (int k = 1; k < NUM_TERM; k++) begin
            acc = round_half_up(acc * t, T_FRAC) + curve_coeffs[axis * NUM_TERM + k];
        end
        acc = round_half_up(acc, 1);
        if (acc > longint'($signed(Q_MAX))) acc = longint'($signed(Q_MAX));
        if (acc < longint'($signed(Q_MIN))) acc = longint'($signed(Q_MIN));
        return acc[OUT_W-1:0];
    endfunction

    function automatic t_point curve_point(input logic signed [T_W-1:0] param);
        longint t;
        t_point p;
        t = longint'(param);
        if (t < 0) t = 0;
        if (t > longint'(T_ONE)) t = longint'(T_ONE);
        p.x = horner_axis(0, t);
        p.y = horner_axis(1, t);
        return p;
    endfunction

    function automatic void reset_curve();
        foreach (curve_regs[i]) curve_regs[i] = '0;
        foreach (curve_coeffs[i]) curve_coeffs[i] = 0;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want, input logic [31:0] got);
        failures++;
        if (failures <= MAX_SHOWN) begin
            $display("Mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_points
        t_point want;
        if (i_rst_n && o_valid) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                note_failure("unexpected point", '0, o_point_x);
            end else begin
                want = pending_points.pop_front();
                if (o_point_x !== want.x) note_failure("point_x", want.x, o_point_x);
                if (o_point_y !== want.y) note_failure("point_y", want.y, o_point_y);
            end
        end
    end

    task automatic send_param(input logic signed [T_W-1:0] param);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start     <= 1'b1;
        i_param_t <= param;
        do @(posedge i_clk); while (busy);
        pending_points.push_back(curve_point(param));
        params_sent++;
    endtask

    task automatic drain_points();
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        if (idx < NUM_REGS_IDX) begin
            curve_regs[idx] = data;
            rebuild_curve();
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_curve(input logic [CFG_W-1:0] p0, input logic [CFG_W-1:0] v0,
                              input logic [CFG_W-1:0] a0, input logic [CFG_W-1:0] p1,
                              input logic [CFG_W-1:0] v1, input logic [CFG_W-1:0] a1);
        write_reg(REG_START_POINT, p0);
        write_reg(REG_START_VEL, v0);
        write_reg(REG_START_ACCEL, a0);
        write_reg(REG_END_POINT, p1);
        write_reg(REG_END_VEL, v1);
        write_reg(REG_END_ACCEL, a1);
        curves_loaded++;
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return Q_ZERO;
            3:       return Q_NEG1;
            4, 5, 6: return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_vector();
        return {rand_coord(), rand_coord()};
    endfunction

    function automatic logic signed [T_W-1:0] rand_param();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                return T_W'($urandom_range(0, 32'(T_ONE)));
            12, 13: begin
                case (r[1:0])
                    2'd0:    return T_ZERO;
                    2'd1:    return T_W'(1);
                    2'd2:    return T_ONE - T_W'(1);
                    default: return T_ONE;
                endcase
            end
            14, 15, 16:
                return r[T_W-1:0];
            17:
                return T_ONE + T_W'($urandom_range(1, 32'(T_HIGH - T_ONE)));
            default:
                return -T_W'($urandom_range(1, 32'(T_HIGH) + 1));
        endcase
    endfunction

    task automatic test_reset_curve();
        send_param(T_LOW);
        send_param(-T_W'(1));
        send_param(T_ZERO);
        send_param(T_HALF);
        send_param(T_ONE);
        send_param(T_HIGH);
        drain_points();
    endtask

    task automatic test_extreme_curves();
        load_curve({Q_MAX, Q_MIN}, {Q_MAX, Q_MIN}, {Q_MAX, Q_MIN},
                   {Q_MAX, Q_MIN}, {Q_MAX, Q_MIN}, {Q_MAX, Q_MIN});
        send_param(T_LOW);
        send_param(-T_W'(1));
        send_param(T_ZERO);
        send_param(T_W'(1));
        send_param(T_HALF);
        send_param(T_ONE - T_W'(1));
        send_param(T_ONE);
        send_param(T_ONE + T_W'(1));
        drain_points();
        load_curve({Q_MAX, Q_MIN}, {Q_MAX, Q_MAX}, {Q_MIN, Q_MAX},
                   {Q_MIN, Q_MAX}, {Q_MIN, Q_MIN}, {Q_MAX, Q_MIN});
        send_param(T_ZERO);
        send_param(T_W'(1));
        send_param(T_HALF >>> 1);
        send_param(T_HALF);
        send_param(T_ONE);
        send_param(T_HIGH);
        drain_points();
    endtask

    task automatic test_spare_index();
        write_reg(IDX_SPARE_LO, {$urandom, $urandom});
        write_reg(IDX_SPARE_HI, {$urandom, $urandom});
        send_param(T_ZERO);
        send_param(T_HALF);
        send_param(T_ONE);
        drain_points();
    endtask

    task automatic test_random_curves();
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            case (round % 3)
                0:       idle_pct = IDLE_NONE;
                1:       idle_pct = IDLE_HEAVY;
                default: idle_pct = IDLE_LIGHT;
            endcase
            drain_points();
            load_curve(rand_vector(), rand_vector(), rand_vector(),
                       rand_vector(), rand_vector(), rand_vector());
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, {$urandom, $urandom});
            end
            for (int n = 0; n < ROUND_POINTS; n++) begin
                send_param(rand_param());
            end
        end
        drain_points();
    endtask

    initial begin
        reset_curve();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_curve();
        test_extreme_curves();
        test_spare_index();
        test_random_curves();

        if (pending_points.size() != 0) begin
            note_failure("missing points", pending_points.size(), '0);
        end
        $display("Evaluated %0d parameters on %0d curves with %0d register writes.",
                 params_sent, curves_loaded, reg_writes);
        $display("Checked %0d points at sender idle rates of 0, 28 and 53 percent.",
                 points_seen);
        if (failures == 0) begin
            $display("tb_quintic_hermite_curve_eval passed");
        end else begin
            $display("tb_quintic_hermite_curve_eval failed");
        end
        $finish;
    end

endmodule
